/* src/acia_pkg.sv */
// types and constants shared by the acia register block
package acia_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned BYTE_W = 8;

    // command codes carried in the input word
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // status register bit positions
    localparam int unsigned ST_RDRF_BIT = 0;
    localparam int unsigned ST_TDRE_BIT = 1;
    localparam int unsigned ST_IRQ_BIT  = 7;

    localparam logic [BYTE_W-1:0] ST_RDRF  = 8'h01;
    localparam logic [BYTE_W-1:0] ST_TDRE  = 8'h02;
    localparam logic [BYTE_W-1:0] ST_DCD   = 8'h04;
    localparam logic [BYTE_W-1:0] ST_OVRN  = 8'h20;

    // control register fields
    localparam logic [1:0] CTRL_MASTER_RESET = 2'b11;
    localparam logic [1:0] CTRL_TX_INT_ON    = 2'b01;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] bus_data;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_ready;
    } acia_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              irq_request;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
    } acia_out_t;

endpackage

/* src/acia_uart_registers.sv */
// acia register block: bus accesses and serial ticks with a registered result word
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   in_word  (acia_in_t)
//  out       output     out_valid / out_stall out_word (acia_out_t)
//  cfg       input      cfg_we                cfg_data (base address)
//
// for each word the state update and the result are worked out in the cycle it is
// accepted and the result sits in the output register on the next cycle.
// a new word is taken every cycle while the output register is free or being emptied.
// reset leaves status at transmit empty, other state cleared, base address zero; out_word is not reset.
// when out_stall holds a result, in_stall is raised until it is taken.
module acia_uart_registers
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  acia_pkg::acia_in_t       in_word,
    output logic                     out_valid,
    input  logic                     out_stall,
    output acia_pkg::acia_out_t      out_word,
    input  logic                     cfg_we,
    input  logic [acia_pkg::ADDR_W-1:0] cfg_data
);
    import acia_pkg::*;

    logic [ADDR_W-1:0] base_addr_reg;
    logic [BYTE_W-1:0] control_reg, control_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0] rx_holding_reg, rx_holding_next;
    logic [BYTE_W-1:0] tx_holding_reg, tx_holding_next;
    logic [BYTE_W-1:0] flags_seen_reg, flags_seen_next;
    logic [BYTE_W-1:0] flags_pending_reg, flags_pending_next;
    logic              rx_irq_reg, rx_irq_next;
    logic              tx_irq_reg, tx_irq_next;
    logic              out_valid_reg;
    acia_out_t         out_word_reg, out_word_next;

    logic              accept;
    logic              is_ctrl;
    logic [BYTE_W-1:0] delta;
    logic              rx_int_on;
    logic              tx_int_on;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign is_ctrl   = (in_word.address == base_addr_reg);
    assign delta     = control_reg ^ in_word.bus_data;

    always_comb
    begin
        control_next       = control_reg;
        status_next        = status_reg;
        rx_holding_next    = rx_holding_reg;
        tx_holding_next    = tx_holding_reg;
        flags_seen_next    = flags_seen_reg;
        flags_pending_next = flags_pending_reg;
        rx_irq_next        = rx_irq_reg;
        tx_irq_next        = tx_irq_reg;
        out_word_next      = '0;
        rx_int_on          = control_reg[7];
        tx_int_on          = (control_reg[6:5] == CTRL_TX_INT_ON);

        case (in_word.cmd)
            CMD_WRITE:
            begin
                if (is_ctrl)
                begin
                    control_next = in_word.bus_data;
                    rx_int_on    = in_word.bus_data[7];
                    tx_int_on    = (in_word.bus_data[6:5] == CTRL_TX_INT_ON);
                    if ((delta[1:0] != 2'b00) && (in_word.bus_data[1:0] == CTRL_MASTER_RESET))
                    begin
                        rx_irq_next        = 1'b0;
                        tx_irq_next        = 1'b0;
                        status_next        = ST_TDRE;
                        flags_seen_next    = '0;
                        flags_pending_next = '0;
                    end
                    if (delta[6:5] != 2'b00)
                        tx_irq_next = tx_int_on && status_next[ST_TDRE_BIT];
                    if (delta[7])
                        rx_irq_next = rx_int_on && status_next[ST_RDRF_BIT];
                end
                else
                begin
                    tx_holding_next          = in_word.bus_data;
                    status_next[ST_TDRE_BIT] = 1'b0;
                    if (tx_int_on)
                        tx_irq_next = 1'b0;
                end
                status_next[ST_IRQ_BIT] = rx_irq_next || tx_irq_next;
            end
            CMD_READ:
            begin
                status_next[ST_IRQ_BIT] = rx_irq_reg || tx_irq_reg;
                if (is_ctrl)
                begin
                    flags_seen_next         = status_next & (ST_DCD | ST_OVRN);
                    out_word_next.read_data = status_next;
                end
                else
                begin
                    // overrun held back until the next data read
                    status_next        = (status_next & ~(ST_RDRF | flags_seen_reg))
                                         | flags_pending_reg;
                    flags_seen_next    = '0;
                    flags_pending_next = '0;
                    if (rx_int_on)
                        rx_irq_next = ((status_next & (ST_RDRF | ST_OVRN)) != '0);
                    status_next[ST_IRQ_BIT] = rx_irq_next || tx_irq_reg;
                    out_word_next.read_data = rx_holding_reg;
                end
            end
            CMD_TICK:
            begin
                if (in_word.rx_valid)
                begin
                    rx_holding_next = in_word.rx_byte;
                    if (status_reg[ST_RDRF_BIT])
                        flags_pending_next = flags_pending_reg | ST_OVRN;
                    status_next[ST_RDRF_BIT] = 1'b1;
                    if (rx_int_on)
                        rx_irq_next = 1'b1;
                end
                if (in_word.tx_ready && !status_reg[ST_TDRE_BIT])
                begin
                    out_word_next.tx_valid   = 1'b1;
                    out_word_next.tx_byte    = tx_holding_reg;
                    status_next[ST_TDRE_BIT] = 1'b1;
                    if (tx_int_on)
                        tx_irq_next = 1'b1;
                end
                status_next[ST_IRQ_BIT] = rx_irq_next || tx_irq_next;
            end
            default:
            begin
            end
        endcase

        out_word_next.irq_request = rx_irq_next || tx_irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg     <= '0;
            control_reg       <= '0;
            status_reg        <= ST_TDRE;
            rx_holding_reg    <= '0;
            tx_holding_reg    <= '0;
            flags_seen_reg    <= '0;
            flags_pending_reg <= '0;
            rx_irq_reg        <= 1'b0;
            tx_irq_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                base_addr_reg <= cfg_data;
            if (accept)
            begin
                control_reg       <= control_next;
                status_reg        <= status_next;
                rx_holding_reg    <= rx_holding_next;
                tx_holding_reg    <= tx_holding_next;
                flags_seen_reg    <= flags_seen_next;
                flags_pending_reg <= flags_pending_next;
                rx_irq_reg        <= rx_irq_next;
                tx_irq_reg        <= tx_irq_next;
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_word_reg <= out_word_next;
    end

    // the interrupt line in a held word matches the two sources it came from
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.irq_request == (rx_irq_reg || tx_irq_reg)))
        else $error("irq_request does not match interrupt sources");

    // a byte sent to the serial side leaves the transmit register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.tx_valid) |-> status_reg[ST_TDRE_BIT])
        else $error("tx byte sent but TDRE clear");

    // a tick never returns read data alongside a sent byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.tx_valid) |-> (out_word_reg.read_data == '0))
        else $error("read data on a transmit word");

    // status irq bit follows the sources after every bus write
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_word.cmd == CMD_WRITE)) |=>
            (status_reg[ST_IRQ_BIT] == (rx_irq_reg || tx_irq_reg)))
        else $error("status IRQ bit out of step after write");

endmodule
